>>> src/crlc_pkg.sv
package crlc_pkg;

	// Field widths of one input item and one result item.
	localparam int CMD_W    = 3;
	localparam int SIZE_W   = 32;
	localparam int ID_W     = 32;
	localparam int START_W  = 16;
	localparam int STATUS_W = 2;

	// Bits of the step counter of the serial remainder unit.
	localparam int STEP_W = $clog2(START_W);

	// Most records that one list command reports.
	localparam int MAX_OUT = 16;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cmd_t CMD_APPEND = 3'd0;
	localparam cmd_t CMD_NEXT   = 3'd1;
	localparam cmd_t CMD_PREV   = 3'd2;
	localparam cmd_t CMD_SHOW   = 3'd3;
	localparam cmd_t CMD_DELMAX = 3'd4;
	localparam cmd_t CMD_LIST   = 3'd5;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_EMPTY    = 2'd1;
	localparam status_t ST_FULL     = 2'd2;
	localparam status_t ST_NOCURSOR = 2'd3;

	// One result item waiting to go to the output register.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [ID_W-1:0]   id;
		status_t           status;
		logic              last;
	} res_t;

endpackage

>>> src/circular_record_list_cursor_top.sv
// Circular record list with a cursor.
// Commands arrive on the slave stream: tuser carries the command code, tdata the record
// size, record id and 1-based start position. Results leave on the master stream: tdata
// carries size and id, tuser the status, and tlast marks the final result of a command.
// One command is worked on at a time; the slave side is ready only while the sequencer
// is idle. A finished result sits in the output register, so the next command can be
// taken while the receiver has not yet taken the last result of the previous one.
// From command transfer to result in the output register: append writes the record;
// show reads the record under the cursor; next or previous steps the cursor, then reads
// the record, placing the cursor first when there is none (for a start above one, by the
// serial divider, one remainder bit per cycle). Delete-largest scans the record RAM,
// reading it once per cycle, then moves each record behind the largest down by a read
// and a write. List emits records one at a time. Commands 6 and 7 give no result.
// All sequencing shares the single record RAM port pair.
// When the receiver stalls, the sequencer holds in its emit state until the output
// register frees up; nothing is lost or repeated.
// Reset empties the list and clears the cursor. The RAM is not cleared; only records
// that have been written are ever read.
module circular_record_list_cursor_top #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: record_size [31:0], record_id [63:32], start_position [79:64]
	input  logic [79:0] s_axis_tdata,
	// tuser: command [2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: out_size [31:0], out_id [63:32]
	output logic [63:0] m_axis_tdata,
	// tuser: status [1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int RW = crlc_pkg::SIZE_W + crlc_pkg::ID_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [3:0] {
		IDLE, APPEND, DIVIDE, STEP, CUR_RD, CUR_DATA, SCAN, SCAN_DONE,
		SH_RD, SH_WR, LIST_RD, LIST_DATA, EMIT
	} state_t;

	state_t state_q;

	crlc_pkg::cmd_t                 cmd_q;
	logic [crlc_pkg::SIZE_W-1:0]    size_q;
	logic [crlc_pkg::ID_W-1:0]      id_q;
	logic [CW-1:0]                  count_q;
	logic [IW-1:0]                  cursor_q;
	logic                           cur_vld_q;
	logic [IW-1:0]                  idx_q;
	logic                           iss_done_q;
	logic                           rd_vld_s1;
	logic [IW-1:0]                  rd_idx_s1;
	logic [IW-1:0]                  best_q;
	logic [crlc_pkg::SIZE_W-1:0]    best_size_q;
	logic [crlc_pkg::ID_W-1:0]      best_id_q;
	logic [CW-1:0]                  rem_q;
	logic [crlc_pkg::START_W-1:0]   dvd_q;
	logic [crlc_pkg::STEP_W-1:0]    step_q;
	crlc_pkg::res_t                 res_q;

	// Record RAM ports.
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;

	logic [crlc_pkg::SIZE_W-1:0] rd_size;
	logic [crlc_pkg::ID_W-1:0]   rd_id;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] idx_p1;
	logic [CW-1:0] list_n;
	logic          out_free;
	logic          in_xfer;

	// Serial remainder unit: one dividend bit per cycle.
	logic [CW:0]   div_t;
	logic [CW:0]   div_d;
	logic [CW-1:0] rem_next;

	crlc_pkg::cmd_t               in_cmd;
	logic [crlc_pkg::START_W-1:0] in_start;

	assign in_cmd   = s_axis_tuser;
	assign in_start = s_axis_tdata[79:64];

	assign rd_size = ram_rdata[crlc_pkg::SIZE_W-1:0];
	assign rd_id   = ram_rdata[RW-1:crlc_pkg::SIZE_W];

	assign cnt_m1   = count_q - CW'(1);
	assign idx_p1   = CW'(idx_q) + CW'(1);
	assign list_n   = (32'(count_q) > crlc_pkg::MAX_OUT) ? CW'(crlc_pkg::MAX_OUT) : count_q;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == IDLE);

	assign div_t    = {rem_q, dvd_q[crlc_pkg::START_W-1]};
	assign div_d    = div_t - {1'b0, count_q};
	assign rem_next = (div_t >= {1'b0, count_q}) ? div_d[CW-1:0] : div_t[CW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = count_q[IW-1:0];
				ram_wdata = {id_q, size_q};
			end
			CUR_RD: begin
				ram_re    = 1'b1;
				ram_raddr = cursor_q;
			end
			SCAN: begin
				ram_re = !iss_done_q;
			end
			SH_RD: begin
				// Read the record behind the gap; it moves down next cycle.
				ram_re    = (idx_p1 < count_q);
				ram_raddr = idx_p1[IW-1:0];
			end
			SH_WR: begin
				ram_we = 1'b1;
			end
			LIST_RD: begin
				ram_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	crlc_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			count_q       <= '0;
			cursor_q      <= '0;
			cur_vld_q     <= 1'b0;
			idx_q         <= '0;
			iss_done_q    <= 1'b0;
			rd_vld_s1     <= 1'b0;
			step_q        <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			// The output register is loaded from the emit state once it is free,
			// and emptied when the receiver takes its transfer.
			if (state_q == EMIT && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end

			case (state_q)
				IDLE: begin
					if (in_xfer) begin
						cmd_q  <= in_cmd;
						size_q <= s_axis_tdata[31:0];
						id_q   <= s_axis_tdata[63:32];
						case (in_cmd) inside
							crlc_pkg::CMD_APPEND: begin
								if (count_q == DEPTH_C) begin
									res_q   <= '{size: '0, id: '0, status: crlc_pkg::ST_FULL,
										last: 1'b1};
									state_q <= EMIT;
								end else begin
									state_q <= APPEND;
								end
							end
							crlc_pkg::CMD_NEXT, crlc_pkg::CMD_PREV, crlc_pkg::CMD_SHOW,
							crlc_pkg::CMD_DELMAX, crlc_pkg::CMD_LIST: begin
								if (count_q == '0) begin
									res_q   <= '{size: '0, id: '0, status: crlc_pkg::ST_EMPTY,
										last: 1'b1};
									state_q <= EMIT;
								end else if (in_cmd == crlc_pkg::CMD_SHOW) begin
									if (cur_vld_q) begin
										state_q <= CUR_RD;
									end else begin
										res_q   <= '{size: '0, id: '0,
											status: crlc_pkg::ST_NOCURSOR, last: 1'b1};
										state_q <= EMIT;
									end
								end else if (in_cmd == crlc_pkg::CMD_DELMAX) begin
									idx_q      <= '0;
									iss_done_q <= 1'b0;
									rd_vld_s1  <= 1'b0;
									state_q    <= SCAN;
								end else if (in_cmd == crlc_pkg::CMD_LIST) begin
									idx_q   <= '0;
									state_q <= LIST_RD;
								end else if (cur_vld_q) begin
									state_q <= STEP;
								end else if (in_start <= crlc_pkg::START_W'(1)) begin
									cursor_q  <= '0;
									cur_vld_q <= 1'b1;
									state_q   <= STEP;
								end else begin
									// Place the cursor at (start - 1) mod count first.
									rem_q   <= '0;
									dvd_q   <= in_start - crlc_pkg::START_W'(1);
									step_q  <= '0;
									state_q <= DIVIDE;
								end
							end
							default: begin
							end
						endcase
					end
				end

				APPEND: begin
					count_q <= count_q + CW'(1);
					res_q   <= '{size: size_q, id: id_q, status: crlc_pkg::ST_OK,
						last: 1'b1};
					state_q <= EMIT;
				end

				DIVIDE: begin
					rem_q  <= rem_next;
					dvd_q  <= {dvd_q[crlc_pkg::START_W-2:0], 1'b0};
					step_q <= step_q + crlc_pkg::STEP_W'(1);
					if (step_q == crlc_pkg::STEP_W'(crlc_pkg::START_W - 1)) begin
						cursor_q  <= rem_next[IW-1:0];
						cur_vld_q <= 1'b1;
						state_q   <= STEP;
					end
				end

				STEP: begin
					if (cmd_q == crlc_pkg::CMD_NEXT) begin
						cursor_q <= (CW'(cursor_q) == cnt_m1) ? '0 : cursor_q + IW'(1);
					end else begin
						cursor_q <= (cursor_q == '0) ? cnt_m1[IW-1:0] : cursor_q - IW'(1);
					end
					state_q <= CUR_RD;
				end

				CUR_RD: begin
					state_q <= CUR_DATA;
				end

				CUR_DATA: begin
					res_q   <= '{size: rd_size, id: rd_id, status: crlc_pkg::ST_OK,
						last: 1'b1};
					state_q <= EMIT;
				end

				SCAN: begin
					// Each read is issued in the cycle before its compare.
					if (!iss_done_q) begin
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= idx_q;
						if (CW'(idx_q) == cnt_m1) begin
							iss_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (rd_vld_s1) begin
						// Strictly greater keeps the first of equal sizes.
						if (rd_idx_s1 == '0 || rd_size > best_size_q) begin
							best_q      <= rd_idx_s1;
							best_size_q <= rd_size;
							best_id_q   <= rd_id;
						end
						if (CW'(rd_idx_s1) == cnt_m1) begin
							state_q <= SCAN_DONE;
						end
					end
				end

				SCAN_DONE: begin
					rd_vld_s1 <= 1'b0;
					res_q     <= '{size: best_size_q, id: best_id_q, status: crlc_pkg::ST_OK,
						last: 1'b1};
					idx_q     <= best_q;
					state_q   <= SH_RD;
				end

				SH_RD: begin
					if (idx_p1 < count_q) begin
						state_q <= SH_WR;
					end else begin
						count_q <= cnt_m1;
						if (cur_vld_q) begin
							if (cursor_q == best_q) begin
								cur_vld_q <= 1'b0;
								cursor_q  <= '0;
							end else if (cursor_q > best_q) begin
								cursor_q <= cursor_q - IW'(1);
							end
						end
						state_q <= EMIT;
					end
				end

				SH_WR: begin
					idx_q   <= idx_p1[IW-1:0];
					state_q <= SH_RD;
				end

				LIST_RD: begin
					state_q <= LIST_DATA;
				end

				LIST_DATA: begin
					res_q   <= '{size: rd_size, id: rd_id, status: crlc_pkg::ST_OK,
						last: (idx_p1 == list_n)};
					state_q <= EMIT;
				end

				EMIT: begin
					if (out_free) begin
						m_axis_tdata  <= {res_q.id, res_q.size};
						m_axis_tuser  <= res_q.status;
						m_axis_tlast  <= res_q.last;
						// Only a list run produces results that are not the last.
						if (res_q.last) begin
							state_q <= IDLE;
						end else begin
							idx_q   <= idx_p1[IW-1:0];
							state_q <= LIST_RD;
						end
					end
				end

				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/crlc_ram.sv
module crlc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> tb/sv/circular_record_list_cursor_top_tb.sv
module circular_record_list_cursor_top_tb;

	// Size of the record list that is built and checked against.
	localparam int LIST_DEPTH = 16;

	// Cycles allowed after the last expected result for any stray result to show up.
	localparam int DRAIN_CYCLES = 120;

	// Hard ceiling on the run.
	localparam int LIMIT_CYCLES = 400000;

	// Random items per idling phase, not counting the ignored command codes.
	localparam int ITEMS_PER_PHASE = 50;

	// The two codes that the block ignores.
	localparam crlc_pkg::cmd_t CMD_UNUSED_A = 3'd6;
	localparam crlc_pkg::cmd_t CMD_UNUSED_B = 3'd7;

	// Idling phases of the run.
	typedef enum int {
		PACE_FREE,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	// One command as it waits to be sent on the slave stream.
	typedef struct packed {
		crlc_pkg::cmd_t                cmd;
		logic [crlc_pkg::SIZE_W-1:0]  size;
		logic [crlc_pkg::ID_W-1:0]    id;
		logic [crlc_pkg::START_W-1:0] start;
	} list_command_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// tdata: record_size [31:0], record_id [63:32], start_position [79:64]
	logic [79:0] s_axis_tdata = '0;
	// tuser: command [2:0]
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tdata: out_size [31:0], out_id [63:32]
	logic [63:0] m_axis_tdata;
	// tuser: status [1:0]
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	circular_record_list_cursor_top #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// Commands not yet offered to the block, and the one currently offered.
	list_command_t pending_commands[$];
	list_command_t offered_command;

	// Results the block still owes, oldest first.
	crlc_pkg::res_t expected_results[$];

	// Our own copy of the list: records, record count and cursor.
	logic [crlc_pkg::SIZE_W-1:0] model_sizes[LIST_DEPTH];
	logic [crlc_pkg::ID_W-1:0]   model_ids[LIST_DEPTH];
	int                          model_count = 0;
	int                          cursor_pos = 0;
	bit                          cursor_set = 1'b0;

	// Record count as the stimulus generator tracks it, so that it can steer the list
	// between filling up to full and draining down to empty.
	int gen_count = 0;
	bit filling_list = 1'b1;

	pace_t pace = PACE_FREE;
	int    mismatches = 0;
	int    cycle_count = 0;

	// Clock, and a single reset pulse at the start of the run.
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The run stops here if the block hangs or falls behind badly.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int sender_idle_pct();
		return (pace == PACE_SENDER_IDLE) ? 85 : (pace == PACE_BOTH) ? 28 : 0;
	endfunction

	function automatic int receiver_stall_pct();
		return (pace == PACE_RECEIVER_STALL) ? 85 : (pace == PACE_BOTH) ? 28 : 0;
	endfunction

	function automatic void expect_result(logic [crlc_pkg::SIZE_W-1:0] size,
			logic [crlc_pkg::ID_W-1:0] id, crlc_pkg::status_t status, logic last);
		crlc_pkg::res_t r;
		r.size = size;
		r.id = id;
		r.status = status;
		r.last = last;
		expected_results.push_back(r);
	endfunction

	// A step with no cursor first drops the cursor at the 1-based start position,
	// wrapped by the record count; 0 and 1 both mean the first record.
	function automatic void place_cursor(logic [crlc_pkg::START_W-1:0] start);
		if (!cursor_set) begin
			cursor_pos = (start <= 1) ? 0 : (int'(start) - 1) % model_count;
			cursor_set = 1'b1;
		end
	endfunction

	// Applies one accepted command to our copy of the list and queues the results
	// that the block must produce for it.
	task automatic predict_command(input list_command_t c);
		int best;
		int n;
		logic [crlc_pkg::SIZE_W-1:0] del_size;
		logic [crlc_pkg::ID_W-1:0]   del_id;
		if (c.cmd == CMD_UNUSED_A || c.cmd == CMD_UNUSED_B)
			return;
		if (c.cmd == crlc_pkg::CMD_APPEND) begin
			if (model_count >= LIST_DEPTH) begin
				expect_result('0, '0, crlc_pkg::ST_FULL, 1'b1);
			end else begin
				model_sizes[model_count] = c.size;
				model_ids[model_count] = c.id;
				model_count++;
				expect_result(c.size, c.id, crlc_pkg::ST_OK, 1'b1);
			end
			return;
		end
		// Every other command on an empty list reports it and changes nothing.
		if (model_count == 0) begin
			expect_result('0, '0, crlc_pkg::ST_EMPTY, 1'b1);
			return;
		end
		case (c.cmd)
			crlc_pkg::CMD_NEXT: begin
				place_cursor(c.start);
				cursor_pos = (cursor_pos + 1) % model_count;
				expect_result(model_sizes[cursor_pos], model_ids[cursor_pos],
					crlc_pkg::ST_OK, 1'b1);
			end
			crlc_pkg::CMD_PREV: begin
				place_cursor(c.start);
				cursor_pos = (cursor_pos == 0) ? model_count - 1 : cursor_pos - 1;
				expect_result(model_sizes[cursor_pos], model_ids[cursor_pos],
					crlc_pkg::ST_OK, 1'b1);
			end
			crlc_pkg::CMD_SHOW: begin
				if (!cursor_set)
					expect_result('0, '0, crlc_pkg::ST_NOCURSOR, 1'b1);
				else
					expect_result(model_sizes[cursor_pos], model_ids[cursor_pos],
						crlc_pkg::ST_OK, 1'b1);
			end
			crlc_pkg::CMD_DELMAX: begin
				// Strictly greater, so that among equal sizes the first one goes.
				best = 0;
				for (int i = 1; i < model_count; i++)
					if (model_sizes[i] > model_sizes[best])
						best = i;
				del_size = model_sizes[best];
				del_id = model_ids[best];
				for (int i = best; i + 1 < model_count; i++) begin
					model_sizes[i] = model_sizes[i + 1];
					model_ids[i] = model_ids[i + 1];
				end
				model_count--;
				// The cursor follows its record; on the deleted record it is cleared.
				if (cursor_set) begin
					if (cursor_pos == best) begin
						cursor_set = 1'b0;
						cursor_pos = 0;
					end else if (cursor_pos > best) begin
						cursor_pos--;
					end
				end
				expect_result(del_size, del_id, crlc_pkg::ST_OK, 1'b1);
			end
			default: begin
				n = (model_count < crlc_pkg::MAX_OUT) ? model_count : crlc_pkg::MAX_OUT;
				for (int i = 0; i < n; i++)
					expect_result(model_sizes[i], model_ids[i], crlc_pkg::ST_OK, i == n - 1);
			end
		endcase
	endtask

	// Slave side. A command is taken at an edge where tvalid and tready are both high;
	// only then is it predicted and the next one considered for offer.
	always @(posedge clk) begin : command_drive
		bit accepted;
		accepted = s_axis_tvalid && s_axis_tready;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (accepted)
				predict_command(offered_command);
			if (!s_axis_tvalid || accepted) begin
				if (pending_commands.size() != 0 &&
						$urandom_range(0, 99) >= sender_idle_pct()) begin
					offered_command = pending_commands.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {offered_command.start, offered_command.id,
						offered_command.size};
					s_axis_tuser <= offered_command.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Master side back-pressure, drawn fresh every cycle.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
	end

	task automatic report_mismatch(input string what, input crlc_pkg::res_t want,
			input crlc_pkg::res_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%s: expected size %h id %h status %0d last %0d, ",
				what, want.size, want.id, want.status, want.last);
			$display("got size %h id %h status %0d last %0d",
				got.size, got.id, got.status, got.last);
		end
	endtask

	// Each result transfer is checked field by field against the oldest expectation.
	always @(posedge clk) begin : result_check
		crlc_pkg::res_t got;
		crlc_pkg::res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.size = m_axis_tdata[31:0];
			got.id = m_axis_tdata[63:32];
			got.status = m_axis_tuser;
			got.last = m_axis_tlast;
			if (expected_results.size() == 0) begin
				report_mismatch("result with none expected", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got.size !== want.size || got.id !== want.id ||
						got.status !== want.status || got.last !== want.last)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	// Queues a command and keeps the generator's record count in step with it.
	function automatic void queue_command(crlc_pkg::cmd_t cmd,
			logic [crlc_pkg::SIZE_W-1:0] size, logic [crlc_pkg::ID_W-1:0] id,
			logic [crlc_pkg::START_W-1:0] start);
		list_command_t c;
		c.cmd = cmd;
		c.size = size;
		c.id = id;
		c.start = start;
		pending_commands.push_back(c);
		if (cmd == crlc_pkg::CMD_APPEND && gen_count < LIST_DEPTH)
			gen_count++;
		else if (cmd == crlc_pkg::CMD_DELMAX && gen_count > 0)
			gen_count--;
	endfunction

	// Random commands that swing the list from empty to full and back. While filling,
	// appends dominate so that appends to a full list happen; while draining, deletes do.
	task automatic queue_random_commands(input int legal_items);
		int queued;
		int r;
		int append_w;
		int delete_w;
		crlc_pkg::cmd_t cmd;
		logic [crlc_pkg::SIZE_W-1:0]  size;
		logic [crlc_pkg::START_W-1:0] start;
		queued = 0;
		while (queued < legal_items) begin
			r = $urandom_range(0, 99);
			append_w = filling_list ? 55 : 10;
			delete_w = filling_list ? 8 : 40;
			if (r < append_w) begin
				cmd = crlc_pkg::CMD_APPEND;
			end else if (r < append_w + delete_w) begin
				cmd = crlc_pkg::CMD_DELMAX;
			end else if (r < 95) begin
				case ($urandom_range(0, 3))
					0: cmd = crlc_pkg::CMD_NEXT;
					1: cmd = crlc_pkg::CMD_PREV;
					2: cmd = crlc_pkg::CMD_SHOW;
					default: cmd = crlc_pkg::CMD_LIST;
				endcase
			end else begin
				cmd = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
			end
			// Small sizes half the time, so that equal largest sizes are common.
			size = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
			case ($urandom_range(0, 3))
				0: start = '0;
				1: start = crlc_pkg::START_W'(1);
				2: start = crlc_pkg::START_W'($urandom_range(2, 40));
				default: start = crlc_pkg::START_W'($urandom);
			endcase
			queue_command(cmd, size, $urandom, start);
			if (cmd != CMD_UNUSED_A && cmd != CMD_UNUSED_B)
				queued++;
			if (filling_list && gen_count == LIST_DEPTH && $urandom_range(0, 3) == 0)
				filling_list = 1'b0;
			else if (!filling_list && gen_count == 0 && $urandom_range(0, 2) == 0)
				filling_list = 1'b1;
		end
	endtask

	task automatic wait_until_drained();
		while (pending_commands.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// Directed part, with no idling on either side.
		pace = PACE_FREE;
		// Every command but append on an empty list.
		queue_command(crlc_pkg::CMD_SHOW, $urandom, $urandom, crlc_pkg::START_W'($urandom));
		queue_command(crlc_pkg::CMD_NEXT, $urandom, $urandom, crlc_pkg::START_W'($urandom));
		queue_command(crlc_pkg::CMD_PREV, $urandom, $urandom, crlc_pkg::START_W'($urandom));
		queue_command(crlc_pkg::CMD_DELMAX, $urandom, $urandom,
			crlc_pkg::START_W'($urandom));
		queue_command(crlc_pkg::CMD_LIST, $urandom, $urandom, crlc_pkg::START_W'($urandom));
		// Extreme record values, then show before any cursor exists.
		queue_command(crlc_pkg::CMD_APPEND, '0, '0, '0);
		queue_command(crlc_pkg::CMD_APPEND, '1, '1, '1);
		queue_command(crlc_pkg::CMD_APPEND, 32'd5, 32'h0000_1234, '0);
		queue_command(crlc_pkg::CMD_SHOW, '0, '0, '0);
		// Start position zero places the cursor on the first record, then steps.
		queue_command(crlc_pkg::CMD_NEXT, '0, '0, '0);
		queue_command(crlc_pkg::CMD_PREV, '0, '0, '0);
		queue_command(crlc_pkg::CMD_LIST, '0, '0, '0);
		// Cursor sits on the largest record when it is deleted, so it is cleared.
		queue_command(crlc_pkg::CMD_NEXT, '0, '0, '0);
		queue_command(crlc_pkg::CMD_DELMAX, '0, '0, '0);
		queue_command(crlc_pkg::CMD_SHOW, '0, '0, '0);
		// Start position far above the count wraps around.
		queue_command(crlc_pkg::CMD_PREV, '0, '0, '1);
		// Two records of equal largest size; the cursor sits behind the first of them.
		queue_command(crlc_pkg::CMD_APPEND, 32'd5, 32'h0000_abcd, '0);
		queue_command(crlc_pkg::CMD_NEXT, '0, '0, '0);
		queue_command(crlc_pkg::CMD_DELMAX, '0, '0, '0);
		queue_command(crlc_pkg::CMD_SHOW, '0, '0, '0);
		// Cursor on the deleted record again, then a start position of one.
		queue_command(crlc_pkg::CMD_DELMAX, '0, '0, '0);
		queue_command(crlc_pkg::CMD_NEXT, '0, '0, 16'd1);
		// The ignored codes, with arbitrary payloads.
		queue_command(CMD_UNUSED_A, $urandom, $urandom, crlc_pkg::START_W'($urandom));
		queue_command(CMD_UNUSED_B, $urandom, $urandom, crlc_pkg::START_W'($urandom));
		queue_command(crlc_pkg::CMD_LIST, '0, '0, '0);
		queue_random_commands(ITEMS_PER_PHASE);
		wait_until_drained();

		pace = PACE_SENDER_IDLE;
		queue_random_commands(ITEMS_PER_PHASE);
		wait_until_drained();

		pace = PACE_RECEIVER_STALL;
		queue_random_commands(ITEMS_PER_PHASE);
		wait_until_drained();

		pace = PACE_BOTH;
		queue_random_commands(ITEMS_PER_PHASE);
		wait_until_drained();

		// Give the block time to emit anything it should not.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/crlc_pkg.sv
src/crlc_ram.sv
src/circular_record_list_cursor_top.sv
tb/sv/circular_record_list_cursor_top_tb.sv
